FILE: rtl/core/hrfc_pkg.sv
// ----------------------------------------------------------------------------
// hrfc_pkg
// Shared types and constants for the HART response frame checker.
// ----------------------------------------------------------------------------
package hrfc_pkg;

    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] TOP_BIT_MASK  = 8'h80;
    localparam logic [2:0] LONG_ADDR_LEN  = 3'd5;
    localparam logic [2:0] SHORT_ADDR_LEN = 3'd1;

    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_ADDR     = 3'd1,
        PH_CMD      = 3'd2,
        PH_COUNT    = 3'd3,
        PH_DATA     = 3'd4,
        PH_CHECK    = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        V_OK    = 3'd0,
        V_NONE  = 3'd1,
        V_TRUNC = 3'd2,
        V_CSUM  = 3'd3,
        V_SHORT = 3'd4,
        V_COMM  = 3'd5
    } verdict_t;

    localparam logic ACT_BYTE      = 1'b0;
    localparam logic ACT_BURST_END = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [2:0]  verdict;
        logic [7:0]  response_code;
        logic [7:0]  device_status;
        logic [7:0]  command_echo;
        logic [7:0]  payload_length;
        logic [31:0] good_total;
        logic [31:0] error_total;
    } result_t;

endpackage

FILE: rtl/core/hart_response_frame_checker.sv
// ----------------------------------------------------------------------------
// hart_response_frame_checker
// Parses HART slave response bursts, streams payload words and one verdict
// per burst, and keeps wrapping good and error counters.
//
//   channel  handshake                   words
//   item     item_valid / item_ready     action, rx_byte
//   result   result_valid / result_ready out_kind .. error_total
//
// One word per cycle unless stalled; its result shows in the next cycle.
// item_ready is low only while a result waits and result_ready is low.
// Reset clears frame state, counters and the result valid flag.
// ----------------------------------------------------------------------------
module hart_response_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        out_kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [2:0]  verdict,
    output logic [7:0]  response_code,
    output logic [7:0]  device_status,
    output logic [7:0]  command_echo,
    output logic [7:0]  payload_length,
    output logic [31:0] good_total,
    output logic [31:0] error_total
);
    import hrfc_pkg::*;

    logic    step;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign step = item_valid && item_ready;

    hrfc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .action    (action),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hrfc_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (res_valid),
        .load_data  (res),
        .space      (item_ready),
        .valid      (result_valid),
        .ready      (result_ready),
        .data       (out_data)
    );

    assign out_kind       = out_data.out_kind;
    assign payload_byte   = out_data.payload_byte;
    assign payload_index  = out_data.payload_index;
    assign verdict        = out_data.verdict;
    assign response_code  = out_data.response_code;
    assign device_status  = out_data.device_status;
    assign command_echo   = out_data.command_echo;
    assign payload_length = out_data.payload_length;
    assign good_total     = out_data.good_total;
    assign error_total    = out_data.error_total;

endmodule

FILE: rtl/core/hrfc_parser.sv
// ----------------------------------------------------------------------------
// hrfc_parser
// Frame state and counters; each received word updates them when it is taken.
// ----------------------------------------------------------------------------
module hrfc_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             action,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output hrfc_pkg::result_t res
);
    import hrfc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  addr_left_reg, addr_left_next;
    logic        is_long_reg, is_long_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  command_reg, command_next;
    logic        seen_reg, seen_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] error_reg, error_next;

    logic        emit_verdict;
    verdict_t    verdict;
    logic [7:0]  index_inc;

    assign index_inc = index_reg + 8'd1;

    // result selection
    always_comb
    begin
        emit_verdict = 1'b0;
        verdict      = V_OK;
        res_valid    = 1'b0;
        res          = '0;
        if (action == ACT_BURST_END)
        begin
            if (phase_reg != PH_DONE)
            begin
                emit_verdict = 1'b1;
                verdict      = seen_reg ? V_TRUNC : V_NONE;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CHECK:
                begin
                    emit_verdict = 1'b1;
                    if (rx_byte != xor_reg)
                        verdict = V_CSUM;
                    else if (count_reg < 8'd2)
                        verdict = V_SHORT;
                    else if ((code_reg & TOP_BIT_MASK) != 8'd0)
                        verdict = V_COMM;
                    else
                        verdict = V_OK;
                end
                PH_DATA:
                begin
                    if (index_reg > 8'd1)
                    begin
                        res_valid         = step;
                        res.out_kind      = KIND_PAYLOAD;
                        res.payload_byte  = rx_byte;
                        res.payload_index = index_reg - 8'd2;
                    end
                end
                default:
                begin
                end
            endcase
        end

        good_next  = good_reg;
        error_next = error_reg;
        if (step && emit_verdict)
        begin
            if (verdict == V_OK)
                good_next = good_reg + 32'd1;
            else
                error_next = error_reg + 32'd1;
        end

        if (emit_verdict)
        begin
            res_valid          = step;
            res.out_kind       = KIND_VERDICT;
            res.verdict        = verdict;
            res.response_code  = code_reg;
            res.device_status  = status_reg;
            res.command_echo   = command_reg;
            res.payload_length = (verdict == V_OK) ? (count_reg - 8'd2) : 8'd0;
            res.good_total     = (verdict == V_OK) ? (good_reg + 32'd1) : good_reg;
            res.error_total    = (verdict == V_OK) ? error_reg : (error_reg + 32'd1);
        end
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        addr_left_next = addr_left_reg;
        is_long_next   = is_long_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        xor_next       = xor_reg;
        code_next      = code_reg;
        status_next    = status_reg;
        command_next   = command_reg;
        seen_next      = seen_reg;
        if (step)
        begin
            if (action == ACT_BURST_END)
            begin
                phase_next     = PH_PREAMBLE;
                addr_left_next = 3'd0;
                is_long_next   = 1'b0;
                count_next     = 8'd0;
                index_next     = 8'd0;
                xor_next       = 8'd0;
                code_next      = 8'd0;
                status_next    = 8'd0;
                command_next   = 8'd0;
                seen_next      = 1'b0;
            end
            else
            begin
                seen_next = 1'b1;
                unique case (phase_reg)
                    PH_PREAMBLE:
                    begin
                        if (rx_byte != PREAMBLE_BYTE)
                        begin
                            is_long_next   = rx_byte[7];
                            addr_left_next = rx_byte[7] ? LONG_ADDR_LEN : SHORT_ADDR_LEN;
                            xor_next       = rx_byte;
                            phase_next     = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        xor_next       = xor_reg ^ rx_byte;
                        addr_left_next = addr_left_reg - 3'd1;
                        if (addr_left_reg == 3'd1)
                            phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        xor_next     = xor_reg ^ rx_byte;
                        command_next = rx_byte;
                        phase_next   = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        xor_next   = xor_reg ^ rx_byte;
                        count_next = rx_byte;
                        index_next = 8'd0;
                        phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if (index_reg == 8'd0)
                            code_next = rx_byte;
                        else if (index_reg == 8'd1)
                            status_next = rx_byte;
                        index_next = index_inc;
                        if (index_inc == count_reg)
                            phase_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        phase_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREAMBLE;
            addr_left_reg <= 3'd0;
            is_long_reg   <= 1'b0;
            count_reg     <= 8'd0;
            index_reg     <= 8'd0;
            xor_reg       <= 8'd0;
            code_reg      <= 8'd0;
            status_reg    <= 8'd0;
            command_reg   <= 8'd0;
            seen_reg      <= 1'b0;
            good_reg      <= 32'd0;
            error_reg     <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            addr_left_reg <= addr_left_next;
            is_long_reg   <= is_long_next;
            count_reg     <= count_next;
            index_reg     <= index_next;
            xor_reg       <= xor_next;
            code_reg      <= code_next;
            status_reg    <= status_next;
            command_reg   <= command_next;
            seen_reg      <= seen_next;
            good_reg      <= good_next;
            error_reg     <= error_next;
        end
    end

endmodule

FILE: rtl/core/hrfc_out_reg.sv
// ----------------------------------------------------------------------------
// hrfc_out_reg
// Result register; takes a new word whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module hrfc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              load_valid,
    input  hrfc_pkg::result_t load_data,
    output logic              space,
    output logic              valid,
    input  logic              ready,
    output hrfc_pkg::result_t data
);
    import hrfc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign space = !valid_reg || ready;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = load_valid;
        else if (ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            data_reg <= load_data;
    end

endmodule
